// ===== hdl/ose_pkg.sv =====
// Shared types and constants for the operand stack engine.
package ose_pkg;

    // Stack sizing
    localparam int STACK_DEPTH = 64;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;

    // Operation codes carried in the action field
    typedef enum logic [2:0] {
        ACT_PUSH = 3'd0,
        ACT_POP  = 3'd1,
        ACT_SWAP = 3'd2,
        ACT_ADD  = 3'd3,
        ACT_READ = 3'd4,
        ACT_NOP  = 3'd5
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_REPORT
    } state_t;

    // Input item
    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] push_value;
    } op_item_t;

    // Result item
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [6:0]               entry_count;
    } res_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;
        logic fill;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_fill;
    } dp_stat_t;

endpackage

// ===== hdl/operand_stack_engine_top.sv =====
// The result strobe comes in the cycle after the item is accepted, except for pop or add with
// three or more entries, which first pass through the fill state to refill the second entry from RAM.
// Throughput: one item per cycle while not busy, the next item is taken while done is high; busy holds
// off the next item during a refill, set by the registered read port of the stack RAM.
// Reset: asynchronous, clears the entry count to an empty stack; RAM needs no clearing.
// Results cannot be stalled by the receiver.
module operand_stack_engine_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ose_pkg::op_item_t  item,
    output logic               busy,
    output logic               done,
    output ose_pkg::res_item_t result
);

    ose_pkg::dp_cmd_t  cmd;
    ose_pkg::dp_stat_t stat;

    ose_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ose_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .stat   (stat),
        .result (result)
    );

endmodule

// ===== hdl/ose_ram.sv =====
// Generic single write port RAM with registered read data.
module ose_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/ose_ctrl.sv =====
// Controller state machine for the operand stack engine.
module ose_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ose_pkg::dp_stat_t stat,
    output ose_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);

    ose_pkg::state_t state_reg;
    ose_pkg::state_t state_next;
    logic            accept;

    assign accept = start && !busy;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ose_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ose_pkg::S_IDLE, ose_pkg::S_REPORT:
            begin
                if (accept)
                begin
                    state_next = stat.need_fill ? ose_pkg::S_FILL : ose_pkg::S_REPORT;
                end
                else
                begin
                    state_next = ose_pkg::S_IDLE;
                end
            end
            ose_pkg::S_FILL:
            begin
                state_next = ose_pkg::S_REPORT;
            end
            default:
            begin
                state_next = ose_pkg::S_IDLE;
            end
        endcase
    end

    // Drive the handshake and datapath commands
    always_comb
    begin
        busy     = 1'b0;
        done     = 1'b0;
        cmd.fill = 1'b0;
        unique case (state_reg)
            ose_pkg::S_IDLE:
            begin
                busy = 1'b0;
            end
            ose_pkg::S_FILL:
            begin
                busy     = 1'b1;
                cmd.fill = 1'b1;
            end
            ose_pkg::S_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        cmd.exec = start && !busy;
    end

endmodule

// ===== hdl/ose_dpath.sv =====
// Datapath: top two entries in registers, deeper entries in RAM.
module ose_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  ose_pkg::dp_cmd_t   cmd,
    input  ose_pkg::op_item_t  item,
    output ose_pkg::dp_stat_t  stat,
    output ose_pkg::res_item_t result
);

    logic [ose_pkg::COUNT_W-1:0]   count_reg;
    logic [ose_pkg::COUNT_W-1:0]   count_next;
    logic [ose_pkg::DATA_W-1:0]    top_reg;
    logic [ose_pkg::DATA_W-1:0]    top_next;
    logic [ose_pkg::DATA_W-1:0]    second_reg;
    logic [ose_pkg::DATA_W-1:0]    second_next;
    logic [1:0]                    status_reg;
    logic [1:0]                    status_next;

    logic                          empty;
    logic                          has_two;
    logic                          has_three;
    logic                          full;
    logic                          spill;
    logic                          fetch;
    logic [ose_pkg::COUNT_W-1:0]   spill_idx;
    logic [ose_pkg::COUNT_W-1:0]   fetch_idx;
    logic [ose_pkg::DATA_W-1:0]    rd_data;
    logic [ose_pkg::COUNT_W+6:0]   count_ext;

    // Count conditions
    assign empty     = (count_reg == '0);
    assign has_two   = (count_reg >= ose_pkg::COUNT_W'(2));
    assign has_three = (count_reg >= ose_pkg::COUNT_W'(3));
    assign full      = (count_reg == ose_pkg::COUNT_W'(ose_pkg::STACK_DEPTH));
    assign spill_idx = count_reg - ose_pkg::COUNT_W'(2);
    assign fetch_idx = count_reg - ose_pkg::COUNT_W'(3);

    // Decode spill on push and refill on pop or add
    always_comb
    begin
        spill = 1'b0;
        fetch = 1'b0;
        if (item.action == ose_pkg::ACT_PUSH)
        begin
            spill = !full && has_two;
        end
        if ((item.action == ose_pkg::ACT_POP) || (item.action == ose_pkg::ACT_ADD))
        begin
            fetch = has_three;
        end
    end

    assign stat.need_fill = fetch;

    ose_ram #(
        .WIDTH (ose_pkg::DATA_W),
        .DEPTH (ose_pkg::STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.exec && spill),
        .wr_addr (spill_idx[ose_pkg::ADDR_W-1:0]),
        .wr_data (second_reg),
        .rd_en   (cmd.exec && fetch),
        .rd_addr (fetch_idx[ose_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Work out the effect of one operation
    always_comb
    begin
        count_next  = count_reg;
        top_next    = top_reg;
        second_next = second_reg;
        status_next = status_reg;
        if (cmd.exec)
        begin
            status_next = ose_pkg::ST_OK;
            unique case (item.action)
                ose_pkg::ACT_PUSH:
                begin
                    if (full)
                    begin
                        status_next = ose_pkg::ST_FULL;
                    end
                    else
                    begin
                        second_next = top_reg;
                        top_next    = item.push_value;
                        count_next  = count_reg + ose_pkg::COUNT_W'(1);
                    end
                end
                ose_pkg::ACT_POP:
                begin
                    if (empty)
                    begin
                        status_next = ose_pkg::ST_SHORT;
                    end
                    else
                    begin
                        top_next   = second_reg;
                        count_next = count_reg - ose_pkg::COUNT_W'(1);
                    end
                end
                ose_pkg::ACT_SWAP:
                begin
                    if (!has_two)
                    begin
                        status_next = ose_pkg::ST_SHORT;
                    end
                    else
                    begin
                        top_next    = second_reg;
                        second_next = top_reg;
                    end
                end
                ose_pkg::ACT_ADD:
                begin
                    if (!has_two)
                    begin
                        status_next = ose_pkg::ST_SHORT;
                    end
                    else
                    begin
                        top_next   = top_reg + second_reg;
                        count_next = count_reg - ose_pkg::COUNT_W'(1);
                    end
                end
                ose_pkg::ACT_READ:
                begin
                    if (empty)
                    begin
                        status_next = ose_pkg::ST_SHORT;
                    end
                end
                default:
                begin
                    status_next = ose_pkg::ST_OK;
                end
            endcase
        end
        // Load the new second entry from RAM
        if (cmd.fill)
        begin
            second_next = rd_data;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ose_pkg::ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Hold the top two entries
    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        second_reg <= second_next;
    end

    // Form the result item
    assign count_ext          = {7'b0, count_reg};
    assign result.status      = status_reg;
    assign result.top_value   = empty ? '0 : top_reg;
    assign result.entry_count = count_ext[6:0];

endmodule

// ===== sim/operand_stack_engine_top_tb.sv =====
// Self-checking testbench for the operand stack engine: directed corner items, then random mixes.
`timescale 1ns / 100ps

module operand_stack_engine_top_tb;

    localparam int CLK_HALF      = 6;
    localparam int CLK_PERIOD    = 2 * CLK_HALF;
    localparam int RESET_CYCLES  = 5;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES  = 4;

    // Action codes outside the defined set; the block treats them as no operation
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    localparam logic signed [ose_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ose_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    ose_pkg::op_item_t  item = '0;
    logic               busy;
    logic               done;
    ose_pkg::res_item_t result;

    // Shadow copy of the stack, updated as each item is accepted
    logic signed [ose_pkg::DATA_W-1:0] shadow_stack [ose_pkg::STACK_DEPTH];
    int                                shadow_count = 0;
    ose_pkg::res_item_t                stack_results_q [$];

    int items_sent   = 0;
    int results_seen = 0;
    int fail_count   = 0;
    int short_hits   = 0;
    int full_hits    = 0;
    int wrapped_adds = 0;

    operand_stack_engine_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Free-running clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Hard limit on run length
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Apply one operation to the shadow stack and return the result it should give
    function automatic ose_pkg::res_item_t stack_apply(ose_pkg::op_item_t op);
        ose_pkg::res_item_t                r;
        logic signed [ose_pkg::DATA_W-1:0] upper;
        logic signed [ose_pkg::DATA_W-1:0] lower;
        logic signed [ose_pkg::DATA_W-1:0] sum;
        r = '0;
        r.status = ose_pkg::ST_OK;
        unique case (op.action)
            ose_pkg::ACT_PUSH:
            begin
                if (shadow_count >= ose_pkg::STACK_DEPTH)
                    r.status = ose_pkg::ST_FULL;
                else
                begin
                    shadow_stack[shadow_count] = op.push_value;
                    shadow_count++;
                end
            end
            ose_pkg::ACT_POP:
            begin
                if (shadow_count == 0)
                    r.status = ose_pkg::ST_SHORT;
                else
                    shadow_count--;
            end
            ose_pkg::ACT_SWAP:
            begin
                if (shadow_count < 2)
                    r.status = ose_pkg::ST_SHORT;
                else
                begin
                    upper = shadow_stack[shadow_count-1];
                    shadow_stack[shadow_count-1] = shadow_stack[shadow_count-2];
                    shadow_stack[shadow_count-2] = upper;
                end
            end
            ose_pkg::ACT_ADD:
            begin
                if (shadow_count < 2)
                    r.status = ose_pkg::ST_SHORT;
                else
                begin
                    upper = shadow_stack[shadow_count-1];
                    lower = shadow_stack[shadow_count-2];
                    sum   = lower + upper;
                    if (lower[ose_pkg::DATA_W-1] == upper[ose_pkg::DATA_W-1] &&
                        sum[ose_pkg::DATA_W-1] != lower[ose_pkg::DATA_W-1])
                        wrapped_adds++;
                    shadow_stack[shadow_count-2] = sum;
                    shadow_count--;
                end
            end
            ose_pkg::ACT_READ:
            begin
                if (shadow_count == 0)
                    r.status = ose_pkg::ST_SHORT;
            end
            default:
            begin
            end
        endcase
        if (r.status == ose_pkg::ST_SHORT)
            short_hits++;
        if (r.status == ose_pkg::ST_FULL)
            full_hits++;
        r.top_value   = (shadow_count == 0) ? '0 : shadow_stack[shadow_count-1];
        r.entry_count = 7'(shadow_count);
        return r;
    endfunction

    function automatic ose_pkg::op_item_t make_op(logic [2:0] act,
                                                  logic signed [ose_pkg::DATA_W-1:0] value);
        ose_pkg::op_item_t op;
        op.action     = act;
        op.push_value = value;
        return op;
    endfunction

    // Mostly full-range values, with a share of extremes and small numbers
    function automatic logic signed [ose_pkg::DATA_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            unique case ($urandom_range(0, 4))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                3: return -1;
                default: return 1;
            endcase
        end
        else if (pick < 40)
            return $signed($urandom_range(0, 16)) - 8;
        return $urandom;
    endfunction

    // Pick an action, push with the given percentage, the rest spread over the others
    function automatic logic [2:0] rand_action(int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return ose_pkg::ACT_PUSH;
        unique case ($urandom_range(0, 9))
            0, 1: return ose_pkg::ACT_POP;
            2, 3: return ose_pkg::ACT_SWAP;
            4, 5: return ose_pkg::ACT_ADD;
            6, 7: return ose_pkg::ACT_READ;
            8: return ose_pkg::ACT_NOP;
            default: return ($urandom_range(0, 1) != 0) ? ACT_SPARE6 : ACT_SPARE7;
        endcase
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_op(ose_pkg::op_item_t op);
        start <= 1'b1;
        item  <= op;
        do
            @(posedge clk);
        while (busy);
        stack_results_q.push_back(stack_apply(op));
        items_sent++;
    endtask

    // Drop start for a random stretch, mostly short, now and then long
    task automatic idle_gap(int gap_pct);
        int len;
        int pick;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                len = $urandom_range(1, 3);
            else if (pick < 95)
                len = $urandom_range(4, 12);
            else
                len = $urandom_range(20, 60);
            start <= 1'b0;
            item  <= make_op(3'($urandom), $urandom);
            repeat (len) @(posedge clk);
        end
    endtask

    task automatic send_gapped(logic [2:0] act, logic signed [ose_pkg::DATA_W-1:0] value,
                               int gap_pct);
        send_op(make_op(act, value));
        idle_gap(gap_pct);
    endtask

    // Every action on an empty stack, plus unused codes, then swap, add, read and pop on a one-entry stack
    task automatic test_empty_stack();
        send_gapped(ose_pkg::ACT_POP,  32'sd5,  30);
        send_gapped(ose_pkg::ACT_READ, '0,      30);
        send_gapped(ose_pkg::ACT_SWAP, '0,      30);
        send_gapped(ose_pkg::ACT_ADD,  '0,      30);
        send_gapped(ose_pkg::ACT_NOP,  -1,      30);
        send_gapped(ACT_SPARE6,        VAL_MAX, 30);
        send_gapped(ACT_SPARE7,        VAL_MIN, 30);
        send_gapped(ose_pkg::ACT_PUSH, -1,      30);
        send_gapped(ose_pkg::ACT_SWAP, '0,      30);
        send_gapped(ose_pkg::ACT_ADD,  '0,      30);
        send_gapped(ose_pkg::ACT_READ, '0,      30);
        send_gapped(ose_pkg::ACT_POP,  '0,      30);
    endtask

    // Extreme values and sums that wrap in both directions
    task automatic test_extremes_and_wrap();
        send_gapped(ose_pkg::ACT_PUSH, VAL_MAX, 30);
        send_gapped(ose_pkg::ACT_PUSH, 32'sd1,  30);
        send_gapped(ose_pkg::ACT_ADD,  '0,      30);
        send_gapped(ose_pkg::ACT_PUSH, VAL_MIN, 30);
        send_gapped(ose_pkg::ACT_ADD,  '0,      30);
        send_gapped(ose_pkg::ACT_PUSH, -1,      30);
        send_gapped(ose_pkg::ACT_PUSH, VAL_MAX, 30);
        send_gapped(ose_pkg::ACT_SWAP, '0,      30);
        send_gapped(ose_pkg::ACT_READ, '0,      30);
        send_gapped(ose_pkg::ACT_ADD,  '0,      30);
        send_gapped(ose_pkg::ACT_POP,  '0,      30);
        send_gapped(ose_pkg::ACT_POP,  '0,      30);
    endtask

    // Fill to the top, push past it, work at the top, then drain past empty
    task automatic test_overflow();
        while (shadow_count < ose_pkg::STACK_DEPTH)
            send_gapped(ose_pkg::ACT_PUSH, rand_value(), 20);
        send_gapped(ose_pkg::ACT_PUSH, VAL_MAX, 20);
        send_gapped(ose_pkg::ACT_PUSH, VAL_MIN, 0);
        send_gapped(ose_pkg::ACT_SWAP, '0, 20);
        send_gapped(ose_pkg::ACT_READ, '0, 20);
        send_gapped(ose_pkg::ACT_ADD,  '0, 20);
        send_gapped(ose_pkg::ACT_PUSH, rand_value(), 20);
        send_gapped(ose_pkg::ACT_PUSH, rand_value(), 20);
        while (shadow_count > 0)
            send_gapped(ose_pkg::ACT_POP, rand_value(), 20);
        send_gapped(ose_pkg::ACT_POP, '0, 20);
    endtask

    // Random walk over the stack depth, biased by the push share
    task automatic test_random_mix(int count, int push_pct, int gap_pct);
        repeat (count)
            send_gapped(rand_action(push_pct), rand_value(), gap_pct);
    endtask

    // Check each result strobe against the oldest expectation
    always @(posedge clk)
    begin
        ose_pkg::res_item_t want;
        if (rst_n && done)
        begin
            if (stack_results_q.size() == 0)
            begin
                $error("result with no item outstanding: status %0d top %0d count %0d",
                       result.status, result.top_value, result.entry_count);
                fail_count++;
            end
            else
            begin
                want = stack_results_q.pop_front();
                results_seen++;
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.top_value !== want.top_value)
                begin
                    $error("top_value: expected %0d, actual %0d",
                           want.top_value, result.top_value);
                    fail_count++;
                end
                if (result.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, result.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Reset, run the tests in turn, drain and report
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_extremes_and_wrap();
        test_overflow();
        test_random_mix(500, 60, 35);
        test_random_mix(300, 45, 0);
        test_random_mix(400, 20, 35);
        test_random_mix(300, 40, 50);

        start <= 1'b0;
        while (stack_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (stack_results_q.size() != 0)
        begin
            $error("%0d results never arrived", stack_results_q.size());
            fail_count++;
        end

        $display("Covered %0d items and %0d results, %0d mismatches.",
                 items_sent, results_seen, fail_count);
        $display("Short-stack errors %0d, full-stack pushes %0d, wrapped sums %0d.",
                 short_hits, full_hits, wrapped_adds);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
